FILE: hw/rtl/umpq_pkg.sv
package umpq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STS_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_EXTRACT    = 2'd2
  } op_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request beat
    logic scan_init;  // start max search at entry 0
    logic scan_step;  // compare one entry
    logic commit;     // update list, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_extract;
    logic empty;
    logic one_left;
    logic scan_last;
  } stat_t;

endpackage

FILE: hw/rtl/umpq_req_if.sv
interface umpq_req_if;
  import umpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

FILE: hw/rtl/umpq_rsp_if.sv
interface umpq_rsp_if;
  import umpq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] extracted;
  logic [STS_W-1:0]         status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output extracted, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input extracted, input status, input occupancy,
                  output ready);
endinterface

FILE: hw/rtl/umpq_ctrl.sv
module umpq_ctrl
  import umpq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_extract && !stat_i.empty) begin
          cmd_o.scan_init = 1'b1;
          state_d         = stat_i.one_left ? S_FIN : S_SCAN;
        end else if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit)     out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result never overwrites one still waiting
  a_commit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit while result beat pending");

  // every commit shows up as a result beat next cycle
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit without result valid");

  // scanning only happens for a non-empty extract
  a_scan_extract: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.scan_init || cmd_o.scan_step) |-> (stat_i.is_extract && !stat_i.empty))
    else $error("max search outside extract");

  // no new request beat while one is in progress
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o)
    else $error("request accepted while busy");

endmodule

FILE: hw/rtl/umpq_dpath.sv
module umpq_dpath
  import umpq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output stat_t                    stat_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic signed [DATA_W-1:0] extracted_o,
  output logic [STS_W-1:0]         status_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  logic signed [DATA_W-1:0] entries_q [CAPACITY];
  logic [CNT_W-1:0]         count_q;
  logic [OP_W-1:0]          op_q;
  logic signed [DATA_W-1:0] value_q;
  logic [IDX_W-1:0]         idx_q;
  logic [IDX_W-1:0]         best_idx_q;
  logic signed [DATA_W-1:0] best_val_q;
  logic signed [DATA_W-1:0] extracted_q;
  logic [STS_W-1:0]         status_q;

  logic                     is_push;
  logic                     full;
  logic signed [DATA_W-1:0] scan_val;
  logic [CNT_W-1:0]         last_pos;

  assign is_push  = (op_q == OP_PUSH_FRONT) || (op_q == OP_PUSH_BACK);
  assign full     = (count_q >= CNT_W'(CAPACITY));
  assign scan_val = entries_q[idx_q];
  assign last_pos = count_q - CNT_W'(1);

  assign stat_o.is_extract = (op_q == OP_EXTRACT);
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.one_left   = (count_q == CNT_W'(1));
  assign stat_o.scan_last  = (CNT_W'(idx_q) == last_pos);

  assign extracted_o = extracted_q;
  assign status_o    = status_q;
  assign occupancy_o = OCC_W'(count_q);

  // request capture and max search
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= opcode_i;
      value_q <= value_i;
    end
    if (cmd_i.scan_init) begin
      idx_q      <= IDX_W'(1);
      best_idx_q <= '0;
      best_val_q <= entries_q[0];
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + IDX_W'(1);
      // ties go to the later entry
      if (scan_val >= best_val_q) begin
        best_idx_q <= idx_q;
        best_val_q <= scan_val;
      end
    end
  end

  // list update and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      extracted_q <= '0;
      status_q    <= ST_OK;
      if (is_push) begin
        if (full) begin
          status_q <= ST_FULL;
        end else if (op_q == OP_PUSH_FRONT) begin
          for (int i = 1; i < CAPACITY; i++) entries_q[i] <= entries_q[i-1];
          entries_q[0] <= value_q;
        end else begin
          entries_q[count_q[IDX_W-1:0]] <= value_q;
        end
      end else if (op_q == OP_EXTRACT) begin
        if (count_q == '0) begin
          status_q <= ST_EMPTY;
        end else begin
          extracted_q <= best_val_q;
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IDX_W'(i) >= best_idx_q) entries_q[i] <= entries_q[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      if (is_push && !full)                               count_q <= count_q + CNT_W'(1);
      else if ((op_q == OP_EXTRACT) && (count_q != '0))   count_q <= count_q - CNT_W'(1);
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> (CNT_W'(idx_q) < count_q))
    else $error("max search past last entry");

  a_best_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && stat_o.is_extract && !stat_o.empty) |-> (CNT_W'(best_idx_q) < count_q))
    else $error("removed entry past last entry");

endmodule

FILE: hw/rtl/unsorted_max_priority_queue.sv
// Unsorted max priority queue: an ordered list of up to CAPACITY signed
// 32-bit values. Extract removes the maximum; among equal maxima the one
// latest in list order goes, and the entries behind it move up one place.
//
// Request channel (req, valid/ready): opcode push front, push back or
// extract max, plus the value to push. Response channel (rsp): one beat
// per request with the extracted value (zero unless an extract succeeded),
// a status (ok, extract on empty, push on full dropped) and the number of
// entries held afterwards.
//
// Timing: one request at a time. A push, an extract on an empty list or an
// unused opcode goes from acceptance through the execute state to its
// registered response beat; an extract on a non-empty list also runs the max
// search, which compares one stored entry per cycle, before the result is
// committed. The next request is taken as soon as the previous result is
// registered, so at most one request is in flight behind a pending response.
//
// Reset clears the entry count and the response valid; stored entries are
// not cleared. If the receiver stalls, the response beat holds and the
// next result waits in the datapath until it is taken.
module unsorted_max_priority_queue
  import umpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  umpq_req_if.sink   req,
  umpq_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  umpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  umpq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .opcode_i    (req.opcode),
    .value_i     (req.value),
    .extracted_o (rsp.extracted),
    .status_o    (rsp.status),
    .occupancy_o (rsp.occupancy)
  );

endmodule

FILE: dv/umpq_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the priority queue, keeps a mirror of the list,
// and checks every response beat against the oldest owed result.
module umpq_checker
  import umpq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  umpq_req_if  req,
  umpq_rsp_if  rsp,
  output int   fails_o,
  output int   owed_o
);

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t            extracted;
    status_e          status;
    logic [OCC_W-1:0] occupancy;
  } rsp_beat_t;

  word_t     list_mirror[$];
  rsp_beat_t owed_rsp[$];
  int        fails = 0;

  // Apply one request to the mirror and return the response it should give.
  function automatic rsp_beat_t apply_request(logic [OP_W-1:0] op, word_t val);
    rsp_beat_t r;
    int        best;
    r.extracted = '0;
    r.status    = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (list_mirror.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          list_mirror.push_front(val);
        end else begin
          list_mirror.push_back(val);
        end
      end
      OP_EXTRACT: begin
        if (list_mirror.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // ties go to the later entry
          best = 0;
          for (int i = 1; i < list_mirror.size(); i++) begin
            if (list_mirror[i] >= list_mirror[best]) best = i;
          end
          r.extracted = list_mirror[best];
          list_mirror.delete(best);
        end
      end
      default: ;  // spare opcode: no change
    endcase
    r.occupancy = OCC_W'(list_mirror.size());
    return r;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h actual %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    rsp_beat_t want;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (owed_rsp.size() == 0) begin
          $error("unexpected response beat: extracted %0h status %0d occupancy %0d",
                 rsp.extracted, rsp.status, rsp.occupancy);
          fails++;
        end else begin
          want = owed_rsp.pop_front();
          check_field("extracted", want.extracted, rsp.extracted);
          check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
          check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(rsp.occupancy));
        end
      end
      if (req.valid && req.ready) owed_rsp.push_back(apply_request(req.opcode, req.value));
      fails_o <= fails;
      owed_o  <= owed_rsp.size();
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

// Top of the priority queue bench: clock, reset, request stimulus and the
// response-side ready pattern. All checking lives in umpq_checker.
module tb;
  import umpq_pkg::*;

  typedef logic signed [DATA_W-1:0] word_t;

  // Opcode 3 is not decoded by the block; it must act as a no-op.
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  localparam word_t W_MAX = 32'sh7fff_ffff;
  localparam word_t W_MIN = 32'sh8000_0000;

  localparam int ITEMS_PER_PHASE = 330;
  localparam int HOLD_LEN        = 300;     // long receiver stall, in cycles
  localparam int CYCLE_LIMIT     = 400_000;
  localparam int TAIL_CYCLES     = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  umpq_req_if req_if ();
  umpq_rsp_if rsp_if ();

  int fails;
  int owed_cnt;

  // idle rates, percent of cycles
  int src_idle_pct = 10;
  int snk_idle_pct = 52;

  // long-stall handshake: main bumps hold_reqs, receiver loop takes it up
  int hold_reqs  = 0;
  int hold_taken = 0;
  int hold_left  = 0;

  int cycles = 0;
  int push_pct;

  unsorted_max_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if)
  );

  umpq_checker u_checker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_if),
    .rsp     (rsp_if),
    .fails_o (fails),
    .owed_o  (owed_cnt)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog. Covers a hung handshake as well as owed beats that never show.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Response side: random back-pressure, or a solid stall while a long
  // hold-off is running. Ready moves on the falling edge only.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_reqs != hold_taken) begin
        hold_left = HOLD_LEN;
        hold_taken++;
      end
      if (hold_left > 0) begin
        rsp_if.ready = 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offer one request beat and return on the edge that accepts it. Valid is
  // left high on return, so back-to-back beats drop it in between only on a random source idle.
  task automatic send_req(input logic [OP_W-1:0] op, input word_t val);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid  = 1'b1;
    req_if.opcode = op;
    req_if.value  = val;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Sender goes quiet until every owed response beat has been taken.
  task automatic drain_all();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    do @(posedge clk_i); while (owed_cnt != 0);
  endtask

  // Value mix: small values to force ties, the extremes, and full-range noise.
  function automatic word_t pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return word_t'($urandom_range(8)) - 4;
    if (sel == 4) begin
      case ($urandom_range(3))
        0: return W_MAX;
        1: return W_MIN;
        2: return '0;
        default: return -1;
      endcase
    end
    return word_t'($urandom());
  endfunction

  // One random request. push_pct swings over time so the list keeps running
  // between empty and full instead of hovering in the middle.
  task automatic random_req();
    int            r;
    logic [OP_W-1:0] op;
    r = $urandom_range(99);
    if (r < 2) begin
      op = OP_SPARE;
    end else if (r < 2 + push_pct) begin
      op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else begin
      op = OP_EXTRACT;
    end
    send_req(op, pick_value());
  endtask

  initial begin
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.opcode = OP_PUSH_FRONT;
    req_if.value  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- directed ----
    // empty list: extract reports empty, spare opcode is a no-op
    send_req(OP_EXTRACT, W_MAX);
    send_req(OP_SPARE, W_MIN);
    // extremes at both ends, with a tied maximum; the later MAX must go
    send_req(OP_PUSH_BACK, W_MAX);
    send_req(OP_PUSH_FRONT, W_MIN);
    send_req(OP_PUSH_BACK, '0);
    send_req(OP_PUSH_BACK, -1);
    send_req(OP_PUSH_FRONT, W_MAX);
    send_req(OP_EXTRACT, '0);
    send_req(OP_SPARE, -1);
    // fill to capacity, mixing ends and repeating a value
    for (int k = 0; k < CAPACITY - 4; k++) begin
      send_req(k[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, (k % 3 == 0) ? word_t'(5) : word_t'(-k));
    end
    // pushes on a full list are dropped
    send_req(OP_PUSH_FRONT, W_MAX);
    send_req(OP_PUSH_BACK, W_MAX);
    send_req(OP_EXTRACT, '0);
    send_req(OP_EXTRACT, '0);
    drain_all();

    // ---- random, three idle phases ----
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin src_idle_pct = 10; snk_idle_pct = 52; end
        1: begin src_idle_pct = 52; snk_idle_pct = 10; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: push_pct = 85;
            1: push_pct = 50;
            default: push_pct = 15;
          endcase
        end
        // receiver stalls for a long stretch while requests keep coming,
        // so the block backs up and holds off its input
        if (ph == 0 && n == 100) hold_reqs++;
        if (ph == 2 && n == 150) hold_reqs++;
        // sender stops until every owed beat is back
        if (n == 200) drain_all();
        random_req();
      end
      drain_all();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0 && owed_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
